/* src/pinned_lru_slot_cache_core_macros.svh */
// Assertion macros used by the checker file of the slot cache.
`ifndef PINNED_LRU_SLOT_CACHE_CORE_MACROS_SVH
`define PINNED_LRU_SLOT_CACHE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PLSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plsc check failed");

// Next-cycle implication, disabled while reset is low.
`define PLSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plsc check failed");

`endif

/* src/plsc_pkg.sv */
// Shared types and field widths of the pinned LRU slot cache.
package plsc_pkg;

    localparam int KIND_W   = 2;
    localparam int LAYER_W  = 16;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int TOTAL_W  = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCESS = 2'd0,
        KIND_PIN    = 2'd1,
        KIND_UNPIN  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT        = 3'd0,
        ST_MISS_FREE  = 3'd1,
        ST_MISS_EVICT = 3'd2,
        ST_MISS_FAIL  = 3'd3,
        ST_PIN_DONE   = 3'd4,
        ST_PIN_IGNORE = 3'd5
    } t_status;

endpackage

/* src/pinned_lru_slot_cache_core.sv */
// Top level of the pinned LRU slot cache: slot table, walk sequencer, result register.
// Usage:
//   Input channel (i_valid, o_stall, i_kind, i_layer_id) carries one request
//   item: access, pin or unpin of a layer. An item is taken at a clock edge
//   with i_valid high and o_stall low. o_stall stays high while an item is
//   being worked on.
//   Output channel (o_valid, i_stall, result fields) carries exactly one
//   result item per request. A result waits in the output register while
//   i_stall is high; the next request is taken meanwhile and its result is
//   held back until the register frees up.
//   Steps: compare walk, decision, an age walk for a hit or a miss that got
//   a slot, result load into the output register; pin, unpin, the reserved
//   kind and failed misses skip the age walk. The next item can be taken in
//   the cycle after the result loads, so a new request is taken only once
//   the last one is through.
//   Both walks stream the slot memory (one read and one write port, registered
//   read data) one entry per cycle.
//   Reset (synchronous, active low) clears every valid and pin mark, the
//   three totals, the sequencer and the output valid. The slot memory is not
//   cleared; entries are used only while their valid mark is set.
module pinned_lru_slot_cache_core #(
    parameter int SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [plsc_pkg::KIND_W-1:0]   i_kind,
    input  logic [plsc_pkg::LAYER_W-1:0]  i_layer_id,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [plsc_pkg::STATUS_W-1:0] o_status,
    output logic [plsc_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [plsc_pkg::LAYER_W-1:0]  o_evicted_layer,
    output logic                          o_fill_request,
    output logic [plsc_pkg::TOTAL_W-1:0]  o_hit_total,
    output logic [plsc_pkg::TOTAL_W-1:0]  o_miss_total,
    output logic [plsc_pkg::TOTAL_W-1:0]  o_eviction_total
);

    // Index and age widths; ages are ranks among valid slots, so 0..SLOTS-1.
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = IW;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = plsc_pkg::LAYER_W + AW;
    localparam logic [CW-1:0] CNT_END = CW'(SLOTS);
    localparam logic [plsc_pkg::TOTAL_W-1:0] TOT_ONE = 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_AGE,
        S_DONE
    } t_state;

    t_state r_state;

    // Per-slot flags in flip-flops.
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_pinned;

    // Slot memory: {layer id, age} per entry, registered read.
    logic [EW-1:0] r_mem [SLOTS];
    logic [EW-1:0] r_rd;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    // Request held for the duration of the walks.
    plsc_pkg::t_kind            r_kind;
    logic [plsc_pkg::LAYER_W-1:0] r_id;

    // Walk counter and the index of the entry whose read data is in r_rd.
    logic [CW-1:0] r_cnt;
    logic          r_pvld;
    logic [IW-1:0] r_pidx;

    // Scan findings.
    logic          r_found;
    logic [IW-1:0] r_fidx;
    logic [AW-1:0] r_fage;
    logic          r_free;
    logic [IW-1:0] r_freeidx;
    logic          r_best;
    logic [IW-1:0] r_bidx;
    logic [AW-1:0] r_bage;
    logic [plsc_pkg::LAYER_W-1:0] r_blay;

    // Target slot for the age walk and its old age (infinite for a free slot).
    logic [IW-1:0] r_s;
    logic [AW-1:0] r_a;
    logic          r_ainf;

    // Result under construction.
    plsc_pkg::t_status            r_res_status;
    logic [IW-1:0]                r_res_slot;
    logic [plsc_pkg::LAYER_W-1:0] r_res_evict;
    logic                         r_res_fill;

    // Running totals.
    logic [plsc_pkg::TOTAL_W-1:0] r_hit_cnt;
    logic [plsc_pkg::TOTAL_W-1:0] r_miss_cnt;
    logic [plsc_pkg::TOTAL_W-1:0] r_evict_cnt;

    // Output register.
    logic                          r_ovld;
    logic [plsc_pkg::STATUS_W-1:0] r_ostatus;
    logic [plsc_pkg::SLOT_W-1:0]   r_oslot;
    logic [plsc_pkg::LAYER_W-1:0]  r_oevict;
    logic                          r_ofill;
    logic [plsc_pkg::TOTAL_W-1:0]  r_ohit;
    logic [plsc_pkg::TOTAL_W-1:0]  r_omiss;
    logic [plsc_pkg::TOTAL_W-1:0]  r_oevtot;

    // Fields of the entry just read, and its flags.
    logic [plsc_pkg::LAYER_W-1:0] rd_layer;
    logic [AW-1:0]                rd_age;
    logic                         p_valid;
    logic                         p_pinned;
    logic                         in_acc;
    logic                         issue;
    logic                         walk_end;
    logic                         age_older;

    assign rd_layer = r_rd[EW-1:AW];
    assign rd_age   = r_rd[AW-1:0];
    assign p_valid  = r_valid[r_pidx];
    assign p_pinned = r_pinned[r_pidx];
    assign in_acc   = i_valid && !o_stall;
    assign issue    = (r_cnt < CNT_END);
    assign walk_end = !issue && !r_pvld;
    // Older-than test of the victim search.
    assign age_older = r_pvld && (rd_age > r_bage);

    assign o_stall = (r_state != S_IDLE);
    assign rd_addr = r_cnt[IW-1:0];

    // Age walk write port: the target gets {id, 0}, younger valid slots age by one.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pidx;
        wr_data = {r_id, AW'(0)};
        if (r_state == S_AGE && r_pvld) begin
            if (r_pidx == r_s) begin
                wr_en = 1'b1;
            end else if (p_valid && (r_ainf || rd_age < r_a)) begin
                wr_en   = 1'b1;
                wr_data = {rd_layer, rd_age + AW'(1)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_pinned    <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_ovld      <= 1'b0;
            r_pvld      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // Drop the result once the receiver takes it, unless a new one loads.
            if (r_ovld && !i_stall && (r_state != S_DONE)) begin
                r_ovld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind  <= plsc_pkg::t_kind'(i_kind);
                        r_id    <= i_layer_id;
                        r_cnt   <= '0;
                        r_pvld  <= 1'b0;
                        r_found <= 1'b0;
                        r_free  <= 1'b0;
                        r_best  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    // Advance the read pointer; compare the entry read last cycle.
                    if (issue) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_pvld <= issue;
                    r_pidx <= r_cnt[IW-1:0];
                    if (r_pvld) begin
                        if (!r_found && p_valid && rd_layer == r_id) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_pidx;
                            r_fage  <= rd_age;
                        end
                        if (!r_free && !p_valid) begin
                            r_free    <= 1'b1;
                            r_freeidx <= r_pidx;
                        end
                        if (p_valid && !p_pinned && (!r_best || age_older)) begin
                            r_best <= 1'b1;
                            r_bidx <= r_pidx;
                            r_bage <= rd_age;
                            r_blay <= rd_layer;
                        end
                    end
                    if (walk_end) begin
                        r_state <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    r_cnt  <= '0;
                    r_pvld <= 1'b0;
                    case (r_kind)
                        plsc_pkg::KIND_ACCESS: begin
                            if (r_found) begin
                                r_hit_cnt    <= r_hit_cnt + TOT_ONE;
                                r_res_status <= plsc_pkg::ST_HIT;
                                r_res_slot   <= r_fidx;
                                r_res_evict  <= '0;
                                r_res_fill   <= 1'b0;
                                r_s          <= r_fidx;
                                r_a          <= r_fage;
                                r_ainf       <= 1'b0;
                                r_state      <= S_AGE;
                            end else begin
                                r_miss_cnt <= r_miss_cnt + TOT_ONE;
                                if (r_free) begin
                                    r_res_status       <= plsc_pkg::ST_MISS_FREE;
                                    r_res_slot         <= r_freeidx;
                                    r_res_evict        <= '0;
                                    r_res_fill         <= 1'b1;
                                    r_s                <= r_freeidx;
                                    r_ainf             <= 1'b1;
                                    r_valid[r_freeidx] <= 1'b1;
                                    r_pinned[r_freeidx] <= 1'b0;
                                    r_state            <= S_AGE;
                                end else if (r_best) begin
                                    r_evict_cnt     <= r_evict_cnt + TOT_ONE;
                                    r_res_status    <= plsc_pkg::ST_MISS_EVICT;
                                    r_res_slot      <= r_bidx;
                                    r_res_evict     <= r_blay;
                                    r_res_fill      <= 1'b1;
                                    r_s             <= r_bidx;
                                    r_a             <= r_bage;
                                    r_ainf          <= 1'b0;
                                    r_pinned[r_bidx] <= 1'b0;
                                    r_state         <= S_AGE;
                                end else begin
                                    r_res_status <= plsc_pkg::ST_MISS_FAIL;
                                    r_res_slot   <= '0;
                                    r_res_evict  <= '0;
                                    r_res_fill   <= 1'b0;
                                    r_state      <= S_DONE;
                                end
                            end
                        end
                        plsc_pkg::KIND_PIN, plsc_pkg::KIND_UNPIN: begin
                            r_res_evict <= '0;
                            r_res_fill  <= 1'b0;
                            r_state     <= S_DONE;
                            if (r_found) begin
                                r_pinned[r_fidx] <= (r_kind == plsc_pkg::KIND_PIN);
                                r_res_status     <= plsc_pkg::ST_PIN_DONE;
                                r_res_slot       <= r_fidx;
                            end else begin
                                r_res_status <= plsc_pkg::ST_PIN_IGNORE;
                                r_res_slot   <= '0;
                            end
                        end
                        default: begin
                            r_res_status <= plsc_pkg::ST_PIN_IGNORE;
                            r_res_slot   <= '0;
                            r_res_evict  <= '0;
                            r_res_fill   <= 1'b0;
                            r_state      <= S_DONE;
                        end
                    endcase
                end

                S_AGE: begin
                    // Read-modify-write one entry per cycle; each write uses the registered read data of its entry.
                    if (issue) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_pvld <= issue;
                    r_pidx <= r_cnt[IW-1:0];
                    if (walk_end) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    // Hold until the output register is free.
                    if (!r_ovld || !i_stall) begin
                        r_ovld    <= 1'b1;
                        r_ostatus <= r_res_status;
                        r_oslot   <= plsc_pkg::SLOT_W'(r_res_slot);
                        r_oevict  <= r_res_evict;
                        r_ofill   <= r_res_fill;
                        r_ohit    <= r_hit_cnt;
                        r_omiss   <= r_miss_cnt;
                        r_oevtot  <= r_evict_cnt;
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_ovld;
    assign o_status         = r_ostatus;
    assign o_slot_index     = r_oslot;
    assign o_evicted_layer  = r_oevict;
    assign o_fill_request   = r_ofill;
    assign o_hit_total      = r_ohit;
    assign o_miss_total     = r_omiss;
    assign o_eviction_total = r_oevtot;

endmodule

/* src/plsc_checker.sv */
// Port-level checker of the slot cache and its bind to the top level.
`include "pinned_lru_slot_cache_core_macros.svh"

module plsc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [plsc_pkg::STATUS_W-1:0] o_status,
    input logic [plsc_pkg::LAYER_W-1:0]  o_evicted_layer,
    input logic                          o_fill_request,
    input logic [plsc_pkg::TOTAL_W-1:0]  o_hit_total
);

    // A stalled result holds.
    `PLSC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_hit_total))

    // An accepted request occupies the block for at least the next cycle.
    `PLSC_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // Fill requests only come with a miss that got a slot.
    `PLSC_ASSERT_IMP(a_fill_status, i_clk, i_rst_n, o_valid && o_fill_request, o_status == plsc_pkg::ST_MISS_FREE || o_status == plsc_pkg::ST_MISS_EVICT)

    // An evicted layer is reported only on eviction.
    `PLSC_ASSERT_IMP(a_evict_zero, i_clk, i_rst_n, o_valid && o_status != plsc_pkg::ST_MISS_EVICT, o_evicted_layer == '0)

endmodule

bind pinned_lru_slot_cache_core plsc_checker u_plsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_evicted_layer (o_evicted_layer),
    .o_fill_request  (o_fill_request),
    .o_hit_total     (o_hit_total)
);

/* sim/tb_pinned_lru_slot_cache_core.sv */
// Testbench for the pinned LRU slot cache core: directed and random requests against a local predictor.
`timescale 1ns / 100ps

module tb_pinned_lru_slot_cache_core;

    localparam int SLOTS = 16;
    // Reserved request kind: the block must treat it like an ignored pin change.
    localparam logic [plsc_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;
    // Longest walk through the block: compare walk, decision, age walk, result load.
    localparam int LATENCY = 2 * SLOTS + 6;
    localparam int DRAIN_CYCLES = 2 * LATENCY;
    // Receiver hold-off that forces the block to stall its input.
    localparam int HOLD_CYCLES = 300;
    // Cycles with no handshake on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int IDLE_PCT = 19;
    localparam int RANDOM_ITEMS = 1000;

    typedef logic [plsc_pkg::LAYER_W-1:0] t_id_q[$];

    // One expected result item, field by field.
    typedef struct packed {
        plsc_pkg::t_status                 status;
        logic [plsc_pkg::SLOT_W-1:0]       slot;
        logic [plsc_pkg::LAYER_W-1:0]      evicted;
        logic                              fill;
        logic [plsc_pkg::TOTAL_W-1:0]      hits;
        logic [plsc_pkg::TOTAL_W-1:0]      misses;
        logic [plsc_pkg::TOTAL_W-1:0]      evictions;
    } t_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [plsc_pkg::KIND_W-1:0]    i_kind = '0;
    logic [plsc_pkg::LAYER_W-1:0]   i_layer_id = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [plsc_pkg::STATUS_W-1:0]  o_status;
    logic [plsc_pkg::SLOT_W-1:0]    o_slot_index;
    logic [plsc_pkg::LAYER_W-1:0]   o_evicted_layer;
    logic                           o_fill_request;
    logic [plsc_pkg::TOTAL_W-1:0]   o_hit_total;
    logic [plsc_pkg::TOTAL_W-1:0]   o_miss_total;
    logic [plsc_pkg::TOTAL_W-1:0]   o_eviction_total;

    // Shadow copy of the slot table and the totals, advanced once per accepted item.
    logic                           slot_held     [SLOTS] = '{default: 1'b0};
    logic                           slot_locked   [SLOTS] = '{default: 1'b0};
    logic [plsc_pkg::LAYER_W-1:0]   slot_layer_id [SLOTS] = '{default: '0};
    int                             slot_rank     [SLOTS] = '{default: 0};
    logic [plsc_pkg::TOTAL_W-1:0]   hits_seen = '0;
    logic [plsc_pkg::TOTAL_W-1:0]   misses_seen = '0;
    logic [plsc_pkg::TOTAL_W-1:0]   evicts_seen = '0;

    t_result              pending_results[$];
    t_id_q                filled_ids;
    int                   error_count = 0;
    int                   items_sent = 0;
    int                   quiet_cycles = 0;
    bit                   no_idle = 1'b0;
    bit                   hold_request = 1'b0;

    pinned_lru_slot_cache_core #(
        .SLOTS(SLOTS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_layer_id      (i_layer_id),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_evicted_layer (o_evicted_layer),
        .o_fill_request  (o_fill_request),
        .o_hit_total     (o_hit_total),
        .o_miss_total    (o_miss_total),
        .o_eviction_total(o_eviction_total)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Cache predictor
    // ------------------------------------------------------------------

    function automatic int find_slot(logic [plsc_pkg::LAYER_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (slot_held[i] && slot_layer_id[i] == id)
                return i;
        return -1;
    endfunction

    // Make slot s the most recent; every valid slot younger than it ages by one.
    // A slot that is not yet valid counts as older than all others.
    function automatic void touch_slot(int s);
        int limit;
        limit = slot_held[s] ? slot_rank[s] : 255;
        for (int i = 0; i < SLOTS; i++)
            if (i != s && slot_held[i] && slot_rank[i] < limit)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic t_result predict_request(logic [plsc_pkg::KIND_W-1:0] kind,
                                                logic [plsc_pkg::LAYER_W-1:0] id);
        t_result r;
        int s;
        int victim;
        r = '0;
        r.status = plsc_pkg::ST_PIN_IGNORE;
        s = find_slot(id);
        if (kind == plsc_pkg::KIND_ACCESS) begin
            if (s >= 0) begin
                hits_seen++;
                touch_slot(s);
                r.status = plsc_pkg::ST_HIT;
                r.slot = s[plsc_pkg::SLOT_W-1:0];
            end else begin
                // Every miss counts, failed ones too.
                misses_seen++;
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_held[i]) begin
                        s = i;
                        break;
                    end
                if (s >= 0) begin
                    r.status = plsc_pkg::ST_MISS_FREE;
                end else begin
                    // Oldest unpinned slot goes; on a tie the lowest index wins.
                    victim = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_held[i] && !slot_locked[i] &&
                            (victim < 0 || slot_rank[i] > slot_rank[victim]))
                            victim = i;
                    s = victim;
                    if (s >= 0) begin
                        r.status = plsc_pkg::ST_MISS_EVICT;
                        r.evicted = slot_layer_id[s];
                        evicts_seen++;
                    end else begin
                        r.status = plsc_pkg::ST_MISS_FAIL;
                    end
                end
                if (s >= 0) begin
                    touch_slot(s);
                    slot_held[s] = 1'b1;
                    slot_locked[s] = 1'b0;
                    slot_layer_id[s] = id;
                    r.slot = s[plsc_pkg::SLOT_W-1:0];
                    r.fill = 1'b1;
                end
            end
        end else if ((kind == plsc_pkg::KIND_PIN || kind == plsc_pkg::KIND_UNPIN) && s >= 0) begin
            slot_locked[s] = (kind == plsc_pkg::KIND_PIN);
            r.status = plsc_pkg::ST_PIN_DONE;
            r.slot = s[plsc_pkg::SLOT_W-1:0];
        end
        r.hits = hits_seen;
        r.misses = misses_seen;
        r.evictions = evicts_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request item, wait for the edge that accepts it, then drop valid
    // at the next falling edge so nothing stale is offered while the block works.
    task automatic send_item(input logic [plsc_pkg::KIND_W-1:0] kind,
                             input logic [plsc_pkg::LAYER_W-1:0] id);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_layer_id <= id;
        do @(posedge i_clk); while (o_stall);
        pending_results = {pending_results, predict_request(kind, id)};
        items_sent++;
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic end_requests();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    function automatic t_id_q make_pool(int size);
        t_id_q pool;
        for (int i = 0; i < size; i++)
            pool = {pool, plsc_pkg::LAYER_W'($urandom_range(0, 65535))};
        return pool;
    endfunction

    // Run a burst of requests over a small set of layers so that hits, pins and
    // evictions interact; a few items use fresh layers to force plain misses.
    task automatic run_episode(input t_id_q pool, input int count, input int acc_pct,
                               input int pin_pct, input int unpin_pct);
        int roll;
        logic [plsc_pkg::KIND_W-1:0] kind;
        logic [plsc_pkg::LAYER_W-1:0] id;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < acc_pct)
                kind = plsc_pkg::KIND_ACCESS;
            else if (roll < acc_pct + pin_pct)
                kind = plsc_pkg::KIND_PIN;
            else if (roll < acc_pct + pin_pct + unpin_pct)
                kind = plsc_pkg::KIND_UNPIN;
            else
                kind = KIND_RESERVED;
            if ($urandom_range(99) < 8)
                id = plsc_pkg::LAYER_W'($urandom_range(0, 65535));
            else
                id = pool[$urandom_range(0, pool.size() - 1)];
            send_item(kind, id);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Drive the result stall at random; on request hold it high for a long
    // stretch so one result parks in the output register and the input backs up.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                i_stall <= 1'b0;
            end else begin
                i_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic compare_field(input string name,
                                 input logic [plsc_pkg::TOTAL_W-1:0] want,
                                 input logic [plsc_pkg::TOTAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Check every accepted result item against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result item with nothing expected, status %0d slot %0d",
                         $time, o_status, o_slot_index);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", plsc_pkg::TOTAL_W'(want.status),
                              plsc_pkg::TOTAL_W'(o_status));
                compare_field("slot_index", plsc_pkg::TOTAL_W'(want.slot),
                              plsc_pkg::TOTAL_W'(o_slot_index));
                compare_field("evicted_layer", plsc_pkg::TOTAL_W'(want.evicted),
                              plsc_pkg::TOTAL_W'(o_evicted_layer));
                compare_field("fill_request", plsc_pkg::TOTAL_W'(want.fill),
                              plsc_pkg::TOTAL_W'(o_fill_request));
                compare_field("hit_total", want.hits, o_hit_total);
                compare_field("miss_total", want.misses, o_miss_total);
                compare_field("eviction_total", want.evictions, o_eviction_total);
            end
        end
    end

    // Abort when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_results.size());
            $display("tb_pinned_lru_slot_cache_core: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extreme layer ids, a hit, applied and ignored pin changes, the reserved kind.
    task automatic test_basic_ops();
        send_item(plsc_pkg::KIND_ACCESS, 16'h0000);
        send_item(plsc_pkg::KIND_ACCESS, 16'hFFFF);
        send_item(plsc_pkg::KIND_ACCESS, 16'h0000);
        send_item(plsc_pkg::KIND_PIN, 16'h0000);
        send_item(plsc_pkg::KIND_PIN, 16'hA5A5);
        send_item(plsc_pkg::KIND_UNPIN, 16'hFFFF);
        send_item(plsc_pkg::KIND_UNPIN, 16'h5A5A);
        send_item(KIND_RESERVED, 16'h0000);
        filled_ids = {filled_ids, 16'h0000};
    endtask

    // Fill the table, evict the oldest unpinned layer, pin everything so a miss
    // fails, then unpin layer 0 so the next miss evicts it and a further miss evicts the new layer.
    task automatic test_evict_and_fail();
        logic [plsc_pkg::LAYER_W-1:0] id;
        for (int i = 2; i < SLOTS; i++) begin
            id = plsc_pkg::LAYER_W'(i * 16'h1111) ^ plsc_pkg::LAYER_W'(i << 3);
            send_item(plsc_pkg::KIND_ACCESS, id);
            filled_ids = {filled_ids, id};
        end
        send_item(plsc_pkg::KIND_ACCESS, 16'h7FFF);
        send_item(plsc_pkg::KIND_ACCESS, 16'h7FFF);
        filled_ids = {filled_ids, 16'h7FFF};
        foreach (filled_ids[i])
            if (i != 0)
                send_item(plsc_pkg::KIND_PIN, filled_ids[i]);
        send_item(plsc_pkg::KIND_ACCESS, 16'h8000);
        send_item(plsc_pkg::KIND_UNPIN, 16'h0000);
        send_item(plsc_pkg::KIND_ACCESS, 16'h8000);
        send_item(plsc_pkg::KIND_ACCESS, 16'h0001);
    endtask

    // Run an unpin-heavy episode over the directed layers, then a stretch with no idling on either side.
    task automatic test_back_to_back();
        run_episode(filled_ids, 40, 30, 5, 62);
        no_idle = 1'b1;
        for (int e = 0; e < 5; e++)
            run_episode(make_pool($urandom_range(4, 24)), 40, 65, 15, 17);
        no_idle = 1'b0;
    endtask

    // Hold the result side while requests keep coming.
    task automatic test_output_hold();
        t_id_q pool;
        pool = make_pool(8);
        hold_request = 1'b1;
        run_episode(pool, 20, 70, 15, 15);
    endtask

    // Mixed episodes: balanced traffic, pin-heavy runs that can lock the whole table,
    // and churn that unpins and evicts.
    task automatic test_random_mix();
        int start;
        int mode;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            mode = $urandom_range(9);
            if (mode < 6)
                run_episode(make_pool($urandom_range(3, 28)), $urandom_range(20, 60),
                            65, 15, 17);
            else if (mode < 8)
                run_episode(make_pool($urandom_range(0, 1) ? SLOTS : $urandom_range(10, 20)),
                            $urandom_range(40, 80), 45, 45, 7);
            else
                run_episode(make_pool($urandom_range(12, 32)), $urandom_range(20, 60),
                            70, 5, 22);
        end
    endtask

    // Drop valid, wait out every expected result and then DRAIN_CYCLES, report.
    task automatic finish_run();
        end_requests();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_pinned_lru_slot_cache_core: PASS");
        else
            $display("tb_pinned_lru_slot_cache_core: FAIL");
        $finish;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_evict_and_fail();
        test_back_to_back();
        test_output_hold();
        test_random_mix();
        finish_run();
    end

endmodule
